// ----- hdl/rrlt_pkg.sv -----
// shared types, constants and helper functions of the request/response latency tracker
// no dependencies; used by every module of the block except rrlt_ram
`default_nettype none

package rrlt_pkg;

   // slot table geometry
   localparam int SLOTS  = 32;
   localparam int SLOT_W = $clog2(SLOTS);

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 4'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd600;
   localparam logic [15:0] LIMIT_RESET   = 16'd32768;

   localparam logic [20:0] USEC_PER_SEC = 21'd1000000;

   // stream payload widths
   localparam int REQ_DATA_W = 128;
   localparam int RSP_FIELDS_W = SLOT_W + 104;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      KIND_MATCH   = 2'd0,
      KIND_DROP    = 2'd1,
      KIND_UNKNOWN = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] ctx;
      logic [31:0] call;
      logic [31:0] sec;
      logic [19:0] usec;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       ssec;
      logic [19:0]       susec;
      logic [31:0]       esec;
      logic [19:0]       eusec;
   } record_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic scan_init;
      logic scan_run;
      logic scan_flush;
      logic clear_table;
      logic alloc;
      logic rel_slot;
      logic emit_unknown;
      logic drain;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_request;
      logic is_response;
      logic over;
      logic oversize;
      logic scan_busy;
      logic matched;
      logic live;
      logic rec_ok;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

   function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] bits);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [SLOT_W-1:0] highest_set(input logic [SLOTS-1:0] bits);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (bits[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

   // bit i set for every i below n
   function automatic logic [SLOTS-1:0] below_mask(input logic [SLOT_W-1:0] n);
      logic [SLOTS-1:0] m;
      m = '0;
      for (int i = 0; i < SLOTS; i++) begin
         m[i] = (SLOT_W'(i) < n);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/rrlt_ram.sv -----
// generic single write port, single read port ram with registered read and read enable
// no dependencies
`default_nettype none

module rrlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

// ----- hdl/rrlt_ctrl.sv -----
// controller state machine of the latency tracker: sequences decode, scan, allocate and drain
// depends on rrlt_pkg
`default_nettype none

module rrlt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire rrlt_pkg::dp_status_type st,
   output      rrlt_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_DECODE  = 7'b0000010,
      ST_FLUSH   = 7'b0000100,
      ST_ALLOC   = 7'b0001000,
      ST_SCAN    = 7'b0010000,
      ST_UNKNOWN = 7'b0100000,
      ST_DRAIN   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (st.is_request) begin
               if (st.over) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_FLUSH;
               end else begin
                  state_in = ST_ALLOC;
               end
            end else if (st.is_response) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (st.scan_busy) begin
               cmd.scan_run   = 1'b1;
               cmd.scan_flush = 1'b1;
            end else begin
               cmd.clear_table = 1'b1;
               state_in        = st.oversize ? ST_DRAIN : ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_DRAIN;
         end
         ST_SCAN: begin
            if (st.matched) begin
               cmd.rel_slot = 1'b1;
               state_in     = ST_DRAIN;
            end else if (st.scan_busy) begin
               cmd.scan_run = 1'b1;
            end else if (st.live) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_UNKNOWN;
            end
         end
         ST_UNKNOWN: begin
            if (st.rec_ok) begin
               cmd.emit_unknown = 1'b1;
               cmd.clear_table  = 1'b1;
               state_in         = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (!st.pend_valid || st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rrlt_datapath.sv -----
// datapath of the latency tracker: slot table, scan pipeline, record staging, output register
// depends on rrlt_pkg and rrlt_ram
`default_nettype none

module rrlt_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rrlt_pkg::ctrl_cmd_type              cmd,
   output      rrlt_pkg::dp_status_type             st,
   input  wire logic                                req_tuser,
   input  wire logic [rrlt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                csr_valid,
   input  wire logic [rrlt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rrlt_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                                rsp_tready,
   output      logic                                rsp_tvalid,
   output      logic [1:0]                          rsp_tuser,
   output      logic [rrlt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                                rsp_tlast
);

   localparam logic [rrlt_pkg::SLOT_W-1:0] TOP_SLOT = rrlt_pkg::SLOT_W'(rrlt_pkg::SLOTS - 1);

   // request fields
   logic [7:0]  in_flags;
   logic [15:0] in_ctx;
   logic [31:0] in_call;
   logic [31:0] in_sec;
   logic [19:0] in_usec;
   logic [15:0] in_len;

   assign in_flags = req_tdata[7:0];
   assign in_ctx   = req_tdata[23:8];
   assign in_call  = req_tdata[55:24];
   assign in_sec   = req_tdata[87:56];
   assign in_usec  = req_tdata[107:88];
   assign in_len   = req_tdata[123:108];

   // configuration
   logic [15:0] timeout_ff, timeout_in;
   logic [15:0] limit_ff, limit_in;

   // captured item
   logic [15:0] ctx_ff;
   logic [31:0] call_ff;
   logic [31:0] tsec_ff;
   logic [19:0] tusec_ff;
   logic [15:0] len_ff;
   logic [31:0] thr_ff;
   logic        to_en_ff;
   logic        is_req_ff, is_rsp_ff, over_ff, oversize_ff;

   // table state
   logic [rrlt_pkg::SLOTS-1:0]  valid_ff, valid_in;
   logic [rrlt_pkg::SLOT_W-1:0] hw_ff, hw_in;
   logic [15:0]                 fill_ff, fill_in;

   // scan pipeline
   logic [rrlt_pkg::SLOTS-1:0]  todo_ff, todo_in;
   logic                        stage_v_ff, stage_v_in;
   logic [rrlt_pkg::SLOT_W-1:0] stage_idx_ff, stage_idx_in;
   logic                        match_ff, match_in;
   logic [rrlt_pkg::SLOT_W-1:0] match_idx_ff, match_idx_in;
   logic                        live_ff, live_in;

   // record staging and output
   logic                   pend_v_ff, pend_v_in;
   rrlt_pkg::record_type   pend_ff, pend_in;
   logic                   out_v_ff, out_v_in;
   rrlt_pkg::record_type   out_ff, out_in;
   logic                   out_last_ff, out_last_in;

   // ram
   logic [rrlt_pkg::ENTRY_W-1:0] ram_rdata;
   rrlt_pkg::entry_type          rd_entry;
   rrlt_pkg::entry_type          wr_entry;
   logic [rrlt_pkg::SLOT_W-1:0]  rd_idx;
   logic [rrlt_pkg::SLOT_W-1:0]  alloc_idx;

   logic scan_act, key_hit, aged, is_hit, need_rec, consume, issue;
   logic out_free, rec_ok, rec_load, push_mid, push_last;
   logic ge, borrow;
   logic [31:0] esec;
   logic [20:0] eusec_w;
   rrlt_pkg::record_type scan_rec, new_rec;
   logic [rrlt_pkg::SLOTS-1:0]  free_slots, rel_valid, rel_cand;
   logic [rrlt_pkg::SLOT_W-1:0] rel_hw;
   logic                        top_hit;

   assign rd_entry = rrlt_pkg::entry_type'(ram_rdata);

   // scan stage evaluation
   assign out_free = !out_v_ff || rsp_tready;
   assign rec_ok   = !pend_v_ff || out_free;
   assign scan_act = cmd.scan_run && !match_ff;
   assign key_hit  = (rd_entry.ctx == ctx_ff) && (rd_entry.call == call_ff);
   assign aged     = to_en_ff && (rd_entry.sec < thr_ff);
   assign is_hit   = !cmd.scan_flush && key_hit;
   assign need_rec = cmd.scan_flush || key_hit || aged;
   assign consume  = scan_act && stage_v_ff && (!need_rec || rec_ok);
   assign rd_idx   = rrlt_pkg::lowest_set(todo_ff);
   assign issue    = scan_act && (todo_ff != '0) && (!stage_v_ff || consume)
                     && !(consume && is_hit);

   // elapsed time of a matched entry, zero when the clock went backwards
   assign ge      = (tsec_ff > rd_entry.sec)
                    || ((tsec_ff == rd_entry.sec) && (tusec_ff >= rd_entry.usec));
   assign borrow  = tusec_ff < rd_entry.usec;
   assign esec    = tsec_ff - rd_entry.sec - {31'd0, borrow};
   assign eusec_w = {1'b0, tusec_ff} + (borrow ? rrlt_pkg::USEC_PER_SEC : 21'd0)
                    - {1'b0, rd_entry.usec};

   always_comb begin
      scan_rec.kind  = is_hit ? rrlt_pkg::KIND_MATCH : rrlt_pkg::KIND_DROP;
      scan_rec.slot  = stage_idx_ff;
      scan_rec.ssec  = rd_entry.sec;
      scan_rec.susec = rd_entry.usec;
      scan_rec.esec  = (is_hit && ge) ? esec : 32'd0;
      scan_rec.eusec = (is_hit && ge) ? eusec_w[19:0] : 20'd0;
      if (cmd.emit_unknown) begin
         new_rec.kind  = rrlt_pkg::KIND_UNKNOWN;
         new_rec.slot  = '0;
         new_rec.ssec  = tsec_ff;
         new_rec.susec = tusec_ff;
         new_rec.esec  = 32'd0;
         new_rec.eusec = 20'd0;
      end else begin
         new_rec = scan_rec;
      end
   end

   assign rec_load  = (consume && need_rec) || cmd.emit_unknown;
   assign push_mid  = rec_load && pend_v_ff;
   assign push_last = cmd.drain && pend_v_ff && out_free;

   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      out_v_in    = out_v_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      if (rsp_tready) begin
         out_v_in = 1'b0;
      end
      if (push_mid || push_last) begin
         out_v_in    = 1'b1;
         out_in      = pend_ff;
         out_last_in = push_last;
      end
      if (push_last) begin
         pend_v_in = 1'b0;
      end
      if (rec_load) begin
         pend_v_in = 1'b1;
         pend_in   = new_rec;
      end
   end

   // scan pipeline control
   always_comb begin
      todo_in      = todo_ff;
      stage_v_in   = stage_v_ff;
      stage_idx_in = stage_idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      live_in      = live_ff;
      if (cmd.scan_init) begin
         todo_in    = valid_ff & rrlt_pkg::below_mask(hw_ff);
         stage_v_in = 1'b0;
         match_in   = 1'b0;
         live_in    = 1'b0;
      end else begin
         if (consume) begin
            stage_v_in = 1'b0;
            if (!need_rec) begin
               live_in = 1'b1;
            end
            if (is_hit) begin
               match_in     = 1'b1;
               match_idx_in = stage_idx_ff;
            end
         end
         if (issue) begin
            todo_in[rd_idx] = 1'b0;
            stage_v_in      = 1'b1;
            stage_idx_in    = rd_idx;
         end
      end
   end

   // allocation and release
   assign free_slots = ~valid_ff & rrlt_pkg::below_mask(hw_ff);
   assign alloc_idx  = (free_slots != '0) ? rrlt_pkg::lowest_set(free_slots) : hw_ff;

   always_comb begin
      rel_valid               = valid_ff;
      rel_valid[match_idx_ff] = 1'b0;
   end
   assign rel_cand = rel_valid & rrlt_pkg::below_mask(match_idx_ff);
   assign rel_hw   = (rel_cand != '0) ? rrlt_pkg::highest_set(rel_cand) + 1'b1 : '0;
   assign top_hit  = ({1'b0, match_idx_ff} + 1'b1) == {1'b0, hw_ff};

   always_comb begin
      valid_in = valid_ff;
      hw_in    = hw_ff;
      fill_in  = fill_ff;
      if (consume && !is_hit && !cmd.scan_flush && aged) begin
         valid_in[stage_idx_ff] = 1'b0;
      end
      if (cmd.alloc) begin
         valid_in[alloc_idx] = 1'b1;
         if ((alloc_idx == hw_ff) && (hw_ff != TOP_SLOT)) begin
            hw_in = hw_ff + 1'b1;
         end
         fill_in = fill_ff + len_ff;
      end
      if (cmd.rel_slot) begin
         valid_in = rel_valid;
         if (top_hit) begin
            hw_in = rel_hw;
            if (rel_hw == '0) begin
               valid_in = '0;
               fill_in  = 16'd0;
            end
         end
      end
      if (cmd.clear_table) begin
         valid_in = '0;
         hw_in    = '0;
         fill_in  = 16'd0;
      end
   end

   assign wr_entry.ctx  = ctx_ff;
   assign wr_entry.call = call_ff;
   assign wr_entry.sec  = tsec_ff;
   assign wr_entry.usec = tusec_ff;

   rrlt_ram #(
      .WIDTH (rrlt_pkg::ENTRY_W),
      .DEPTH (rrlt_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc),
      .wr_addr (alloc_idx),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (rd_idx),
      .rd_data (ram_rdata)
   );

   // configuration writes
   always_comb begin
      timeout_in = timeout_ff;
      limit_in   = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            rrlt_pkg::CSR_TIMEOUT: timeout_in = csr_data;
            rrlt_pkg::CSR_LIMIT:   limit_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= rrlt_pkg::TIMEOUT_RESET;
         limit_ff    <= rrlt_pkg::LIMIT_RESET;
         valid_ff    <= '0;
         hw_ff       <= '0;
         fill_ff     <= 16'd0;
         todo_ff     <= '0;
         stage_v_ff  <= 1'b0;
         match_ff    <= 1'b0;
         live_ff     <= 1'b0;
         pend_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
         is_req_ff   <= 1'b0;
         is_rsp_ff   <= 1'b0;
         over_ff     <= 1'b0;
         oversize_ff <= 1'b0;
      end else begin
         timeout_ff <= timeout_in;
         limit_ff   <= limit_in;
         valid_ff   <= valid_in;
         hw_ff      <= hw_in;
         fill_ff    <= fill_in;
         todo_ff    <= todo_in;
         stage_v_ff <= stage_v_in;
         match_ff   <= match_in;
         live_ff    <= live_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
         if (cmd.load_item) begin
            is_req_ff   <= !req_tuser && in_flags[0];
            is_rsp_ff   <= req_tuser && in_flags[1];
            over_ff     <= ({1'b0, fill_ff} + {1'b0, in_len}) > {1'b0, limit_ff};
            oversize_ff <= in_len > limit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_idx_ff <= stage_idx_in;
      match_idx_ff <= match_idx_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
      out_last_ff  <= out_last_in;
      if (cmd.load_item) begin
         ctx_ff   <= in_ctx;
         call_ff  <= in_call;
         tsec_ff  <= in_sec;
         tusec_ff <= in_usec;
         len_ff   <= in_len;
         to_en_ff <= in_sec >= {16'd0, timeout_ff};
         thr_ff   <= in_sec - {16'd0, timeout_ff};
      end
   end

   assign st.is_request  = is_req_ff;
   assign st.is_response = is_rsp_ff;
   assign st.over        = over_ff;
   assign st.oversize    = oversize_ff;
   assign st.scan_busy   = (todo_ff != '0) || stage_v_ff;
   assign st.matched     = match_ff;
   assign st.live        = live_ff;
   assign st.rec_ok      = rec_ok;
   assign st.pend_valid  = pend_v_ff;
   assign st.out_free    = out_free;

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = rrlt_pkg::RSP_DATA_W'({out_ff.eusec, out_ff.esec, out_ff.susec,
                                              out_ff.ssec, out_ff.slot});

endmodule

`default_nettype wire

// ----- hdl/request_response_latency_tracker.sv -----
// top level of the request/response latency tracker: controller, datapath and checks
// depends on rrlt_pkg, rrlt_ctrl and rrlt_datapath (which holds rrlt_ram)
`default_nettype none

// Tracks outstanding remote calls in a table of rrlt_pkg::SLOTS slots and reports their
// latency. A request (req_tuser 0) with first-fragment flag bit 0 set adds msg_length to the
// buffer fill; when the fill would pass buffer_limit every pending slot is reported as a drop
// record and the table is flushed, then the request takes the lowest free slot (an oversized
// request takes none). A response (req_tuser 1) with last-fragment flag bit 1 set scans the
// pending slots in order: timed-out slots give drop records, a slot with the same context and
// call identifiers gives a match record with start and elapsed time and is freed, and a
// response that matches nothing while no slot stays live gives one unknown-drop record and
// resets the table. The final record of each request or response has rsp_tlast set. One item
// is worked at a time. A response or a flushing request reads the pending slots below the
// high-water mark one after another, since the slot memory gives one entry per cycle through
// its single read port while no record is held up by rsp_tready. Each record held up by
// rsp_tready adds its wait. The last record of an item may still sit in the output register
// while the next item is taken. Items whose flags do not qualify give no record. No clearing
// pass is needed after reset. Configuration writes are always taken (csr_ready is tied high)
// and are meant to occur only while the block is idle.

module request_response_latency_tracker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // fields from bit 0: packet_flags 8, context 16, call_id 32, time_sec 32,
   // time_usec 20, msg_length 16, zero fill 4
   input  wire logic [rrlt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd: 0 request, 1 response
   input  wire logic                                req_tuser,
   // record stream
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // fields from bit 0: slot 5, start_sec 32, start_usec 20, elapsed_sec 32,
   // elapsed_usec 20, zero fill
   output      logic [rrlt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // record_kind: 0 match, 1 dropped request, 2 unknown response
   output      logic [1:0]                          rsp_tuser,
   // last record caused by one request or response
   output      logic                                rsp_tlast,
   // register writes: index 0 timeout_seconds, index 1 buffer_limit
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [rrlt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rrlt_pkg::CSR_DATA_W-1:0]     csr_data
);

   rrlt_pkg::ctrl_cmd_type  cmd;
   rrlt_pkg::dp_status_type status;

   // register writes complete in one transfer
   assign csr_ready = 1'b1;

   // sequencing of each transfer: decode, flush or scan, allocate, drain of last record
   rrlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .st        (status),
      .cmd       (cmd)
   );

   // slot table, scan pipeline and record output register
   rrlt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // a new item never starts while a record of the previous one is still staged
   a_staged_drained: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !status.pend_valid)
      else $error("request taken with a record still staged");

   // an unknown-drop record always closes its response
   a_unknown_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == rrlt_pkg::KIND_UNKNOWN)) |-> rsp_tlast)
      else $error("unknown-drop record without tlast");

   // the top slot lies at or above the high-water mark and is never reported
   a_top_slot_hidden: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != rrlt_pkg::KIND_UNKNOWN))
      |-> (rsp_tdata[rrlt_pkg::SLOT_W-1:0] != rrlt_pkg::SLOT_W'(rrlt_pkg::SLOTS - 1)))
      else $error("record reports the top slot");
`endif

endmodule

`default_nettype wire
